// File: hdl/svp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types, constants and the degree sine table for sprite projection.
// ----------------------------------------------------------------------------
package svp_pkg;

   // Heading bounds of the quadrant culling rule
   localparam logic [8:0] H_35  = 9'd35;
   localparam logic [8:0] H_55  = 9'd55;
   localparam logic [8:0] H_125 = 9'd125;
   localparam logic [8:0] H_145 = 9'd145;
   localparam logic [8:0] H_215 = 9'd215;
   localparam logic [8:0] H_235 = 9'd235;
   localparam logic [8:0] H_305 = 9'd305;
   localparam logic [8:0] H_325 = 9'd325;
   localparam logic [8:0] H_359 = 9'd359;
   localparam logic [9:0] FULL_TURN = 10'd360;

   // Configuration register indexes
   localparam logic [1:0] CSR_PLANE_DISTANCE    = 2'd0;
   localparam logic [1:0] CSR_HALF_SCREEN_WIDTH = 2'd1;

   // Q14 sine over a quarter turn
   localparam logic [14:0] QUARTER_SINE [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // Classified item passed from front to back
   typedef struct packed {
      logic              culled;
      logic              on_object;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic signed [15:0] sin_q14;
      logic signed [15:0] cos_q14;
   } item_type;

   // Sine in Q14 of an angle 0..359 degrees
   function automatic logic signed [15:0] sine_q14(input logic [8:0] deg);
      logic [14:0] mag;
      logic        neg;
      begin
         mag = '0;
         neg = 1'b0;
         if (deg <= 9'd90) begin
            mag = QUARTER_SINE[deg[6:0]];
         end else if (deg <= 9'd180) begin
            mag = QUARTER_SINE[7'(9'd180 - deg)];
         end else if (deg <= 9'd270) begin
            mag = QUARTER_SINE[7'(deg - 9'd180)];
            neg = 1'b1;
         end else begin
            mag = QUARTER_SINE[7'(9'd360 - deg)];
            neg = 1'b1;
         end
         sine_q14 = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   endfunction

endpackage
`default_nettype wire

// File: hdl/svp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svp_front
// Forms offsets, folds the heading, applies culling and looks up sine/cosine.
// ----------------------------------------------------------------------------
module svp_front (
   input  wire logic [14:0]       req_viewer_x,
   input  wire logic [14:0]       req_viewer_y,
   input  wire logic [8:0]        req_heading_deg,
   input  wire logic [14:0]       req_object_x,
   input  wire logic [14:0]       req_object_y,
   output svp_pkg::item_type      item
);
   import svp_pkg::*;

   logic signed [15:0] dx;
   logic signed [15:0] dy;
   logic [8:0]         h;
   logic [9:0]         hc_sum;
   logic [8:0]         hc;
   logic               cull;

   // Offsets from object to viewer
   assign dx = $signed({1'b0, req_viewer_x}) - $signed({1'b0, req_object_x});
   assign dy = $signed({1'b0, req_viewer_y}) - $signed({1'b0, req_object_y});

   // Fold heading into 0..359 and form the cosine angle
   assign h      = (req_heading_deg >= 9'(FULL_TURN)) ? 9'(req_heading_deg - 9'(FULL_TURN))
                                                     : req_heading_deg;
   assign hc_sum = {1'b0, h} + 10'd90;
   assign hc     = (hc_sum >= FULL_TURN) ? 9'(hc_sum - FULL_TURN) : hc_sum[8:0];

   // Quadrant culling
   always_comb begin
      cull = 1'b0;
      if (!dy[15] && h >= H_35 && h <= H_145) cull = 1'b1;
      if (dy[15] && h >= H_215 && h <= H_325) cull = 1'b1;
      if (!dx[15] && ((h >= H_305 && h <= H_359) || h <= H_55)) cull = 1'b1;
      if (dx[15] && h >= H_125 && h <= H_235) cull = 1'b1;
   end

   assign item.culled    = cull;
   assign item.on_object = (dx == 16'sd0) && (dy == 16'sd0);
   assign item.dx        = dx;
   assign item.dy        = dy;
   assign item.sin_q14   = sine_q14(h);
   assign item.cos_q14   = sine_q14(hc);

endmodule
`default_nettype wire

// File: hdl/svp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svp_queue
// Two-word queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module svp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  svp_pkg::item_type      push_word,
   input  wire logic              pop,
   output svp_pkg::item_type      pop_word,
   output logic                   empty,
   output logic                   full
);
   import svp_pkg::*;

   item_type   mem_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_word = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

// File: hdl/svp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svp_back
// Sequential arithmetic: rotation, scaling, square root and two divisions.
// ----------------------------------------------------------------------------
module svp_back #(
   parameter int TEXTURE_EDGE = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [11:0]       plane_distance,
   input  wire logic [11:0]       half_screen_width,
   input  wire logic              q_empty,
   input  svp_pkg::item_type      q_word,
   output logic                   q_pop,
   output logic                   rsp_strobe,
   output logic                   rsp_visible,
   output logic [23:0]            rsp_distance_q8,
   output logic signed [15:0]     rsp_screen_column,
   output logic [14:0]            rsp_sprite_height
);
   import svp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_SCALE0 = 3'd2;
   localparam logic [2:0] ST_SCALE1 = 3'd3;
   localparam logic [2:0] ST_ROOT   = 3'd4;
   localparam logic [2:0] ST_CDIV   = 3'd5;
   localparam logic [2:0] ST_HDIV   = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   localparam logic [47:0] HEIGHT_SCALE = 48'(TEXTURE_EDGE * 256);

   logic [2:0]         state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   item_type           item_ff, item_in;
   logic signed [31:0] num_ff, num_in;
   logic signed [31:0] den_ff, den_in;
   logic [31:0]        sq_ff, sq_in;
   logic signed [47:0] acc_ff, acc_in;
   logic [47:0]        rad_ff, rad_in;
   logic [25:0]        srem_ff, srem_in;
   logic [23:0]        root_ff, root_in;
   logic [47:0]        dq_ff, dq_in;
   logic [32:0]        drem_ff, drem_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] col_ff, col_in;
   logic [14:0]        hgt_ff, hgt_in;
   logic               strobe_ff, strobe_in;
   logic               vis_ff, vis_in;
   logic [23:0]        dist_ff, dist_in;
   logic signed [15:0] ocol_ff, ocol_in;
   logic [14:0]        ohgt_ff, ohgt_in;

   logic signed [15:0] rx;
   logic signed [15:0] mul_a, mul_b;
   logic signed [31:0] prod;
   logic signed [47:0] num_ext, den_ext, p_ext, w_ext;
   logic [25:0]        srem_sh, trial;
   logic               s_ge;
   logic [25:0]        srem_nx;
   logic [23:0]        root_nx;
   logic [32:0]        drem_sh;
   logic               d_ge;
   logic [32:0]        drem_nx;
   logic [47:0]        dq_nx;

   assign rx = item_ff.on_object ? 16'sd1 : item_ff.dx;

   // Operand select for the shared 16x16 multiplier
   always_comb begin
      case (cnt_ff)
         6'd0:    begin mul_a = item_ff.dy; mul_b = item_ff.cos_q14; end
         6'd1:    begin mul_a = rx;         mul_b = item_ff.sin_q14; end
         6'd2:    begin mul_a = rx;         mul_b = item_ff.cos_q14; end
         6'd3:    begin mul_a = item_ff.dy; mul_b = item_ff.sin_q14; end
         6'd4:    begin mul_a = item_ff.dx; mul_b = item_ff.dx;      end
         default: begin mul_a = item_ff.dy; mul_b = item_ff.dy;      end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign num_ext = 48'(num_ff);
   assign den_ext = 48'(den_ff);
   assign p_ext   = 48'($signed({1'b0, plane_distance}));
   assign w_ext   = 48'($signed({1'b0, half_screen_width}));

   // One square root digit
   assign srem_sh = {srem_ff[23:0], rad_ff[47:46]};
   assign trial   = {root_ff, 2'b01};
   assign s_ge    = (srem_sh >= trial);
   assign srem_nx = s_ge ? (srem_sh - trial) : srem_sh;
   assign root_nx = {root_ff[22:0], s_ge};

   // One restoring division bit
   assign drem_sh = {drem_ff[31:0], dq_ff[47]};
   assign d_ge    = (drem_sh >= {1'b0, dvs_ff});
   assign drem_nx = d_ge ? (drem_sh - {1'b0, dvs_ff}) : drem_sh;
   assign dq_nx   = {dq_ff[46:0], d_ge};

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      item_in   = item_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      sq_in     = sq_ff;
      acc_in    = acc_ff;
      rad_in    = rad_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      dq_in     = dq_ff;
      drem_in   = drem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      col_in    = col_ff;
      hgt_in    = hgt_ff;
      strobe_in = 1'b0;
      vis_in    = vis_ff;
      dist_in   = dist_ff;
      ocol_in   = ocol_ff;
      ohgt_in   = ohgt_ff;
      q_pop     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_word;
               num_in  = '0;
               den_in  = '0;
               sq_in   = '0;
               cnt_in  = '0;
               if (q_word.culled) begin
                  strobe_in = 1'b1;
                  vis_in    = 1'b0;
                  dist_in   = '0;
                  ocol_in   = '0;
                  ohgt_in   = '0;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            case (cnt_ff)
               6'd0:    num_in = num_ff + prod;
               6'd1:    num_in = num_ff - prod;
               6'd2:    den_in = den_ff + prod;
               6'd3:    den_in = den_ff + prod;
               default: sq_in  = sq_ff + 32'(prod);
            endcase
            if (cnt_ff == 6'd5) begin
               cnt_in   = '0;
               state_in = ST_SCALE0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_SCALE0: begin
            acc_in   = num_ext * p_ext;
            state_in = ST_SCALE1;
         end
         ST_SCALE1: begin
            acc_in   = acc_ff + den_ext * w_ext;
            rad_in   = {sq_ff, 16'd0};
            srem_in  = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            srem_in = srem_nx;
            root_in = root_nx;
            rad_in  = {rad_ff[45:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd23) begin
               cnt_in  = '0;
               drem_in = '0;
               if (den_ff == 32'sd0) begin
                  if (num_ff > 32'sd0)      col_in = 16'sh7fff;
                  else if (num_ff < 32'sd0) col_in = 16'sh8000;
                  else col_in = $signed({4'd0, half_screen_width});
                  // Divide height scale by the fresh root
                  dq_in    = HEIGHT_SCALE * {36'd0, plane_distance};
                  dvs_in   = {8'd0, root_nx};
                  state_in = ST_HDIV;
               end else begin
                  dq_in    = acc_ff[47] ? 48'(-acc_ff) : 48'(acc_ff);
                  dvs_in   = den_ff[31] ? 32'(-den_ff) : 32'(den_ff);
                  neg_in   = acc_ff[47] ^ den_ff[31];
                  state_in = ST_CDIV;
               end
            end
         end
         ST_CDIV: begin
            dq_in   = dq_nx;
            drem_in = drem_nx;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               // Saturate the column
               if (neg_ff) begin
                  col_in = (dq_nx > 48'd32768) ? 16'sh8000 : 16'(-$signed(dq_nx[16:0]));
               end else begin
                  col_in = (dq_nx > 48'd32767) ? 16'sh7fff : $signed(dq_nx[15:0]);
               end
               cnt_in   = '0;
               drem_in  = '0;
               dq_in    = HEIGHT_SCALE * {36'd0, plane_distance};
               dvs_in   = {8'd0, root_ff};
               state_in = ST_HDIV;
            end
         end
         ST_HDIV: begin
            dq_in   = dq_nx;
            drem_in = drem_nx;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               // Zero divisor gives all ones and lands on the ceiling
               hgt_in   = (dq_nx > 48'd32767) ? 15'h7fff : dq_nx[14:0];
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            vis_in    = 1'b1;
            dist_in   = root_ff;
            ocol_in   = col_ff;
            ohgt_in   = hgt_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      dq_ff   <= dq_in;
      drem_ff <= drem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      col_ff  <= col_in;
      hgt_ff  <= hgt_in;
      vis_ff  <= vis_in;
      dist_ff <= dist_in;
      ocol_ff <= ocol_in;
      ohgt_ff <= ohgt_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_visible       = vis_ff;
   assign rsp_distance_q8   = dist_ff;
   assign rsp_screen_column = ocol_ff;
   assign rsp_sprite_height = ohgt_ff;

endmodule
`default_nettype wire

// File: hdl/sprite_view_projection_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_view_projection_core
// Culls one object against a viewer and projects it to column and height.
// ----------------------------------------------------------------------------
// An object is taken when start is high and busy is low; busy rises only
// while the two-word queue behind the front is full. A culled object is
// posted in the cycle after the back takes it from the queue; a visible one
// passes there through taking it from the queue, six products on the shared
// 16x16 multiplier, two scaling steps, 24 square root digits, 48 column
// division bits (skipped when the rotated denominator is zero), 48 height
// division bits and posting. Each result shows for one cycle under
// rsp_strobe and cannot be held off, in order of acceptance.
module sprite_view_projection_core #(
   parameter int TEXTURE_EDGE = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [14:0]       req_viewer_x,
   input  wire logic [14:0]       req_viewer_y,
   input  wire logic [8:0]        req_heading_deg,
   input  wire logic [14:0]       req_object_x,
   input  wire logic [14:0]       req_object_y,
   output logic                   rsp_strobe,
   output logic                   rsp_visible,
   output logic [23:0]            rsp_distance_q8,
   output logic signed [15:0]     rsp_screen_column,
   output logic [14:0]            rsp_sprite_height,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [11:0]       csr_data
);
   import svp_pkg::*;

   logic [11:0] plane_ff, plane_in;
   logic [11:0] half_ff, half_in;
   item_type    front_word;
   item_type    back_word;
   logic        q_full, q_empty, q_pop, push;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign push      = start && !q_full;

   // Register writes
   always_comb begin
      plane_in = plane_ff;
      half_in  = half_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PLANE_DISTANCE:    plane_in = csr_data;
            CSR_HALF_SCREEN_WIDTH: half_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= 12'd277;
         half_ff  <= 12'd320;
      end else begin
         plane_ff <= plane_in;
         half_ff  <= half_in;
      end
   end

   svp_front u_front (
      .req_viewer_x    (req_viewer_x),
      .req_viewer_y    (req_viewer_y),
      .req_heading_deg (req_heading_deg),
      .req_object_x    (req_object_x),
      .req_object_y    (req_object_y),
      .item            (front_word)
   );

   svp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (front_word),
      .pop       (q_pop),
      .pop_word  (back_word),
      .empty     (q_empty),
      .full      (q_full)
   );

   svp_back #(
      .TEXTURE_EDGE (TEXTURE_EDGE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .plane_distance    (plane_ff),
      .half_screen_width (half_ff),
      .q_empty           (q_empty),
      .q_word            (back_word),
      .q_pop             (q_pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_visible       (rsp_visible),
      .rsp_distance_q8   (rsp_distance_q8),
      .rsp_screen_column (rsp_screen_column),
      .rsp_sprite_height (rsp_sprite_height)
   );

endmodule
`default_nettype wire
